### rtl/core/assert_macros.svh
// Assertion macros shared by the S-DES RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication check on the rising clock edge, masked while reset is low.
`define CHK_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication check, masked while reset is low.
`define CHK_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/sdes_pkg.sv
// S-DES package: types, S-box tables and permutation functions.
// No dependencies; used by sdes_keysched and sdes_encrypt_byte.
package sdes_pkg;

	typedef logic [9:0] key_t;
	typedef logic [7:0] byte_t;
	typedef logic [3:0] nib_t;

	// Round subkeys handed from the key schedule to the datapath
	typedef struct packed {
		byte_t k1;
		byte_t k2;
	} subkeys_t;

	// S-boxes indexed [row][col]
	localparam logic [1:0] S0_BOX [0:3][0:3] = '{
		'{2'd1, 2'd0, 2'd3, 2'd2},
		'{2'd3, 2'd2, 2'd1, 2'd0},
		'{2'd0, 2'd2, 2'd1, 2'd3},
		'{2'd3, 2'd1, 2'd3, 2'd2}
	};
	localparam logic [1:0] S1_BOX [0:3][0:3] = '{
		'{2'd0, 2'd1, 2'd2, 2'd3},
		'{2'd2, 2'd0, 2'd1, 2'd3},
		'{2'd3, 2'd0, 2'd1, 2'd0},
		'{2'd2, 2'd1, 2'd0, 2'd3}
	};

	// Position 1 of every table is the MSB of the value read
	function automatic key_t perm_p10(input key_t k);
		return {k[7], k[5], k[8], k[3], k[6], k[0], k[9], k[1], k[2], k[4]};
	endfunction

	function automatic byte_t perm_p8(input key_t c);
		return {c[4], c[7], c[3], c[6], c[2], c[5], c[0], c[1]};
	endfunction

	function automatic byte_t perm_ip(input byte_t b);
		return {b[6], b[2], b[5], b[7], b[4], b[0], b[3], b[1]};
	endfunction

	function automatic byte_t perm_ip_inv(input byte_t b);
		return {b[4], b[7], b[5], b[3], b[1], b[6], b[0], b[2]};
	endfunction

	function automatic byte_t perm_ep(input nib_t r);
		return {r[0], r[3], r[2], r[1], r[2], r[1], r[0], r[3]};
	endfunction

	function automatic nib_t perm_p4(input nib_t s);
		return {s[2], s[0], s[1], s[3]};
	endfunction

	// Row from outer bits, column from inner bits
	function automatic logic [1:0] sbox0(input nib_t x);
		return S0_BOX[{x[3], x[0]}][x[2:1]];
	endfunction

	function automatic logic [1:0] sbox1(input nib_t x);
		return S1_BOX[{x[3], x[0]}][x[2:1]];
	endfunction

	// One Feistel round: left nibble is XORed with P4(S(EP(right) ^ key))
	function automatic byte_t round_fk(input byte_t bits, input byte_t sub);
		byte_t x;
		nib_t  s;
		x = perm_ep(bits[3:0]) ^ sub;
		s = {sbox0(x[7:4]), sbox1(x[3:0])};
		return {bits[7:4] ^ perm_p4(s), bits[3:0]};
	endfunction

endpackage

### rtl/core/sdes_keysched.sv
// S-DES key register and subkey generation (P10, rotations, P8).
// Depends on sdes_pkg.
module sdes_keysched
	import sdes_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cfg_valid,
	output logic     cfg_ready,
	input  key_t     cipher_key,
	output subkeys_t subkeys
);

	key_t key_q;
	key_t p10;
	logic [4:0] lo1, hi1, lo3, hi3;

	// Key register, writes always taken
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (cfg_valid) begin
			key_q <= cipher_key;
		end
	end

	// Halves rotated left by one for K1, by three in total for K2
	always_comb begin
		p10 = perm_p10(key_q);
		lo1 = {p10[8:5], p10[9]};
		hi1 = {p10[3:0], p10[4]};
		lo3 = {lo1[2:0], lo1[4:3]};
		hi3 = {hi1[2:0], hi1[4:3]};
		subkeys.k1 = perm_p8({lo1, hi1});
		subkeys.k2 = perm_p8({lo3, hi3});
	end

endmodule

### rtl/core/sdes_encrypt_byte.sv
// S-DES byte encryptor top level: three-stage pipeline over IP, two rounds, IP inverse.
// Depends on sdes_pkg, sdes_keysched and assert_macros.svh.
//
// Usage:
//   Config channel (cfg_valid/cfg_ready, cipher_key) loads the 10-bit key; cfg_ready
//   is always high. Write the key only while no item is in flight.
//   Input channel (in_valid/in_ready, plain_byte) takes one plaintext item per cycle while in_ready is high.
//   Output channel (out_valid/out_ready, cipher_byte) returns one ciphertext item
//   per input item, in order.
// Pipeline: an accepted input item passes through stage 1 (IP and round with K1),
//   stage 2 (swap and round with K2) and stage 3 (IP inverse into the output
//   register); out_valid rises when the item reaches stage 3.
//   Throughput: one item per cycle while out_ready stays high.
// Reset: key clears to zero, all stage valid bits clear; no items in flight.
// Stall: when out_ready is low the pipeline fills behind the output register and
//   in_ready falls once all three stages hold items; nothing is dropped or repeated.
`include "assert_macros.svh"

module sdes_encrypt_byte
	import sdes_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  cfg_valid,
	output logic  cfg_ready,
	input  key_t  cipher_key,
	input  logic  in_valid,
	output logic  in_ready,
	input  byte_t plain_byte,
	output logic  out_valid,
	input  logic  out_ready,
	output byte_t cipher_byte
);

	subkeys_t subkeys;
	logic     valid_s1, valid_s2, valid_s3;
	byte_t    data_s1, data_s2, data_s3;
	logic     ready_s1, ready_s2, ready_s3;

	sdes_keysched u_keysched (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cipher_key (cipher_key),
		.subkeys    (subkeys)
	);

	// Stage advance: a stage loads when it is empty or its item moves on
	assign ready_s3 = !valid_s3 || out_ready;
	assign ready_s2 = !valid_s2 || ready_s3;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign in_ready = ready_s1;

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (ready_s1) valid_s1 <= in_valid;
			if (ready_s2) valid_s2 <= valid_s1;
			if (ready_s3) valid_s3 <= valid_s2;
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (ready_s1 && in_valid) begin
			data_s1 <= round_fk(perm_ip(plain_byte), subkeys.k1);
		end
		if (ready_s2 && valid_s1) begin
			data_s2 <= round_fk({data_s1[3:0], data_s1[7:4]}, subkeys.k2);
		end
		if (ready_s3 && valid_s2) begin
			data_s3 <= perm_ip_inv(data_s2);
		end
	end

	assign out_valid   = valid_s3;
	assign cipher_byte = data_s3;

	// Checks
	`CHK_IMPL(a_full_when_blocked, !in_ready, valid_s1 && valid_s2 && valid_s3,
		"input blocked while a stage is empty")
	`CHK_NEXT(a_accept_fills_s1, in_valid && in_ready, valid_s1,
		"accepted item did not reach stage 1")
	`CHK_NEXT(a_s2_holds_on_stall, valid_s2 && !ready_s3, valid_s2 && $stable(data_s2),
		"stage 2 item changed while stalled")

endmodule

### sim/sdes_byte_checker.sv
// Scoreboard for sdes_encrypt_byte: tracks key writes, predicts the ciphertext
// of every accepted plaintext item and checks the results in order.
// Depends on sdes_pkg for the key and byte types.
module sdes_byte_checker
	import sdes_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  cfg_valid,
	input  logic  cfg_ready,
	input  key_t  cipher_key,
	input  logic  in_valid,
	input  logic  in_ready,
	input  byte_t plain_byte,
	input  logic  out_valid,
	input  logic  out_ready,
	input  byte_t cipher_byte,
	output int    fail_count,
	output int    pending
);

	// Permutation tables, one hex digit per position, position 1 = MSB of the source
	localparam logic [39:0] P10_POS   = 40'h35274A1986;
	localparam logic [39:0] P8_POS    = 40'h00637485A9;
	localparam logic [39:0] IP_POS    = 40'h0026314857;
	localparam logic [39:0] IPINV_POS = 40'h0041357286;
	localparam logic [39:0] EP_POS    = 40'h0041232341;
	localparam logic [39:0] P4_POS    = 40'h0000002431;

	// Substitution boxes, [row][col]
	localparam logic [1:0] SBOX_LEFT [4][4] = '{
		'{2'd1, 2'd0, 2'd3, 2'd2},
		'{2'd3, 2'd2, 2'd1, 2'd0},
		'{2'd0, 2'd2, 2'd1, 2'd3},
		'{2'd3, 2'd1, 2'd3, 2'd2}
	};
	localparam logic [1:0] SBOX_RIGHT [4][4] = '{
		'{2'd0, 2'd1, 2'd2, 2'd3},
		'{2'd2, 2'd0, 2'd1, 2'd3},
		'{2'd3, 2'd0, 2'd1, 2'd0},
		'{2'd2, 2'd1, 2'd0, 2'd3}
	};

	key_t  key_copy;
	byte_t cipher_due [$];
	byte_t due;

	// Pick n bits out of a w-bit value in table order
	function automatic logic [9:0] pick_bits(input logic [9:0] v, input int w,
			input logic [39:0] pos, input int n);
		logic [9:0] r;
		int p;
		r = '0;
		for (int i = 0; i < n; i++) begin
			p = int'(pos[4*(n-1-i) +: 4]);
			r = {r[8:0], v[w-p]};
		end
		return r;
	endfunction

	function automatic logic [4:0] rotl5(input logic [4:0] v, input int s);
		return (v << s) | (v >> (5 - s));
	endfunction

	// One Feistel round; right nibble passes through
	function automatic byte_t feistel(input byte_t bits, input byte_t sub);
		logic [9:0] mix;
		byte_t x;
		logic [3:0] s;
		mix = pick_bits({6'd0, bits[3:0]}, 4, EP_POS, 8);
		x = mix[7:0] ^ sub;
		s = {SBOX_LEFT[{x[7], x[4]}][x[6:5]], SBOX_RIGHT[{x[3], x[0]}][x[2:1]]};
		mix = pick_bits({6'd0, s}, 4, P4_POS, 4);
		return {bits[7:4] ^ mix[3:0], bits[3:0]};
	endfunction

	// Full cipher: key schedule, IP, two rounds around a swap, IP inverse
	function automatic byte_t encrypt_byte(input key_t k, input byte_t p);
		logic [9:0] p10, k1w, k2w, b;
		logic [4:0] lo, hi;
		byte_t bits;
		p10 = pick_bits(k, 10, P10_POS, 10);
		lo = rotl5(p10[9:5], 1);
		hi = rotl5(p10[4:0], 1);
		k1w = pick_bits({lo, hi}, 10, P8_POS, 8);
		lo = rotl5(lo, 2);
		hi = rotl5(hi, 2);
		k2w = pick_bits({lo, hi}, 10, P8_POS, 8);
		b = pick_bits({2'b00, p}, 8, IP_POS, 8);
		bits = feistel(b[7:0], k1w[7:0]);
		bits = {bits[3:0], bits[7:4]};
		bits = feistel(bits, k2w[7:0]);
		b = pick_bits({2'b00, bits}, 8, IPINV_POS, 8);
		return b[7:0];
	endfunction

	task automatic report_mismatch(input string msg);
		$display("mismatch @%0t: %s", $time, msg);
		fail_count++;
	endtask

	initial begin
		fail_count = 0;
		pending = 0;
	end

	// Watch all three channels on the rising edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_copy = '0;
			cipher_due.delete();
			pending = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				key_copy = cipher_key;
			// results before new items: latency keeps a fresh item out of this edge
			if (out_valid && out_ready) begin
				if (cipher_due.size() == 0) begin
					report_mismatch($sformatf("ciphertext item %02h with none due",
						cipher_byte));
				end else begin
					due = cipher_due.pop_front();
					if (cipher_byte !== due)
						report_mismatch($sformatf("cipher_byte %02h, want %02h",
							cipher_byte, due));
				end
			end
			if (in_valid && in_ready)
				cipher_due.push_back(encrypt_byte(key_copy, plain_byte));
			pending = cipher_due.size();
		end
	end

endmodule

### sim/sdes_encrypt_byte_tb.sv
// Testbench top for sdes_encrypt_byte: clock, reset, key writes and plaintext
// stimulus with random idling on both sides; checking is in sdes_byte_checker.
// Depends on sdes_pkg, sdes_encrypt_byte and sdes_byte_checker.
module sdes_encrypt_byte_tb;
	import sdes_pkg::*;

	localparam int RANDOM_ITEMS = 1500;
	localparam int PHASES       = 6;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int SETTLE       = 4;
	localparam int DRAIN_CYCLES = 8;
	localparam int DIR_COUNT    = 15;

	// Directed pairs: textbook key and vector, extreme keys and bytes
	localparam key_t DIR_KEY [DIR_COUNT] = '{
		10'h282, 10'h282, 10'h282, 10'h282, 10'h282, 10'h282, 10'h282,
		10'h000, 10'h000, 10'h000,
		10'h3FF, 10'h3FF, 10'h3FF,
		10'h200, 10'h001
	};
	localparam byte_t DIR_PLAIN [DIR_COUNT] = '{
		8'h97, 8'h00, 8'hFF, 8'h80, 8'h01, 8'h55, 8'hAA,
		8'h00, 8'hFF, 8'h5A,
		8'h00, 8'hFF, 8'hA5,
		8'h3C, 8'hC3
	};

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	logic  cfg_valid = 1'b0;
	logic  cfg_ready;
	key_t  cipher_key = '0;
	logic  in_valid = 1'b0;
	logic  in_ready;
	byte_t plain_byte = '0;
	logic  out_valid;
	logic  out_ready = 1'b0;
	byte_t cipher_byte;

	int fail_count;
	int pending;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int cycle_count = 0;

	sdes_encrypt_byte uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cipher_key  (cipher_key),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.plain_byte  (plain_byte),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.cipher_byte (cipher_byte)
	);

	sdes_byte_checker cipher_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cipher_key  (cipher_key),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.plain_byte  (plain_byte),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.cipher_byte (cipher_byte),
		.fail_count  (fail_count),
		.pending     (pending)
	);

	always #10 clk = ~clk;

	// Receiver stalls at random
	always @(negedge clk) begin
		out_ready = ($urandom_range(99) >= recv_idle_pct);
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Key write only with the pipeline empty; called at a falling edge
	task automatic load_key(input key_t k);
		in_valid = 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
		cfg_valid = 1'b1;
		cipher_key = k;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Offer one plaintext item after a random gap; valid stays high back to back
	task automatic push_plain(input byte_t b);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid = 1'b1;
		plain_byte = b;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	initial begin
		key_t phase_key;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed items, no idling
		for (int i = 0; i < DIR_COUNT; i++) begin
			if (i == 0 || DIR_KEY[i] != DIR_KEY[i-1])
				load_key(DIR_KEY[i]);
			push_plain(DIR_PLAIN[i]);
		end

		// random items: receiver-heavy stalls, then sender-heavy gaps, then none
		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase / 2)
				0: begin
					send_idle_pct = 11;
					recv_idle_pct = 81;
				end
				1: begin
					send_idle_pct = 81;
					recv_idle_pct = 11;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			case (phase)
				0: phase_key = 10'h3FF;
				2: phase_key = 10'h000;
				4: phase_key = 10'h155;
				default: phase_key = key_t'($urandom_range(1023));
			endcase
			load_key(phase_key);
			for (int n = 0; n < RANDOM_ITEMS / PHASES; n++)
				push_plain(byte_t'($urandom_range(255)));
		end

		// drain, then idle for DRAIN_CYCLES to catch anything stray
		in_valid = 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
